/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the buddy page allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/bpa_pkg.sv */
// Package with sizes, codes and types of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned NUM_FRAMES = 1024;
  localparam int unsigned TOP_ORDER  = 10;

  localparam int unsigned FW   = $clog2(NUM_FRAMES);
  localparam int unsigned LW   = FW + 1;
  localparam int unsigned CW   = (LW > TOP_ORDER + 1) ? LW : TOP_ORDER + 1;
  localparam int unsigned HW   = $clog2(TOP_ORDER + 1);
  localparam int unsigned KW   = $clog2(TOP_ORDER + 2);
  localparam int unsigned ST_W = 5;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FRAME_W  = 10;
  localparam int unsigned END_W    = 11;
  localparam int unsigned ORDER_W  = 4;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESERVE = 2'd0,
    MODE_BUILD   = 2'd1,
    MODE_ALLOC   = 2'd2,
    MODE_FREE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_DONE      = 2'd0,
    RES_NO_BLOCK  = 2'd1,
    RES_NOT_ALLOC = 2'd2
  } result_e;

  localparam logic [ST_W-1:0] ST_UNOWNED   = 5'd29;
  localparam logic [ST_W-1:0] ST_ALLOCATED = 5'd30;
  localparam logic [ST_W-1:0] ST_RESERVED  = 5'd31;
  localparam logic [LW-1:0]   LINK_NULL    = LW'(NUM_FRAMES);

endpackage

/* hw/rtl/bpa_if.sv */
// Request and response channel interfaces of the buddy page allocator.
interface bpa_req_if;
  import bpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FRAME_W-1:0] first_frame;
  logic [END_W-1:0]   end_frame;
  logic [ORDER_W-1:0] req_order;
  modport source (output valid, mode, first_frame, end_frame, req_order, input ready);
  modport sink (input valid, mode, first_frame, end_frame, req_order, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  block_frame;
  logic [ORDER_W-1:0]  block_order;
  modport source (output valid, status, block_frame, block_order, input ready);
  modport sink (input valid, status, block_frame, block_order, output ready);
endinterface

/* hw/rtl/bpa_ram.sv */
// Single-port-write, single-port-read frame table memory with registered read data.
module bpa_ram #(
  parameter int unsigned WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [bpa_pkg::FW-1:0] waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [bpa_pkg::FW-1:0] raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  import bpa_pkg::*;

  logic [WIDTH-1:0] mem [NUM_FRAMES];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/buddy_page_allocator.sv */
// Top level of the buddy page allocator: sequencer, free-list heads and frame tables.
// The allocator keeps a status, an allocation order and next/prev links for each of
// NUM_FRAMES frames in four on-chip tables, and one free-list head per order in
// registers. One request is handled at a time and ready is high only while idle; a
// finished response waits in an output register, so the next request may be taken
// before the response is consumed. All work runs through a small sequencer that does
// one table read (registered) and one write per table each cycle. After reset a clearing
// pass over all NUM_FRAMES frames initializes the status and link tables before the
// first request is accepted. Reserve marks each frame in range. Allocate searches the
// orders upward and splits off halves; a request above the top order fails without a
// search, and a search that finds every list empty fails too. Free reports a frame
// that is not allocated, otherwise merges it with free buddies of equal order. Build
// is the slow command: a first pass clears the tables frame by frame, keeping reserved
// marks, then a scan reads frames one at a time and pushes each block it forms; it is
// meant to be run rarely, after the reserved ranges have been marked.
`include "assert_macros.svh"

module buddy_page_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  import bpa_pkg::*;

  typedef enum logic [19:0] {
    S_CLR  = 20'b00000000000000000001,
    S_IDLE = 20'b00000000000000000010,
    S_RES  = 20'b00000000000000000100,
    S_B1R  = 20'b00000000000000001000,
    S_B1W  = 20'b00000000000000010000,
    S_B2   = 20'b00000000000000100000,
    S_B2R  = 20'b00000000000001000000,
    S_B2C  = 20'b00000000000010000000,
    S_AS   = 20'b00000000000100000000,
    S_AN   = 20'b00000000001000000000,
    S_AL   = 20'b00000000010000000000,
    S_F1   = 20'b00000000100000000000,
    S_FM   = 20'b00000001000000000000,
    S_FB   = 20'b00000010000000000000,
    S_FC   = 20'b00000100000000000000,
    S_FE   = 20'b00001000000000000000,
    S_P1   = 20'b00010000000000000000,
    S_P2   = 20'b00100000000000000000,
    S_OUT  = 20'b01000000000000000000,
    S_SPARE = 20'b10000000000000000000
  } state_e;

  localparam logic [CW-1:0] TOP_SIZE = CW'(1) << TOP_ORDER;
  localparam logic [CW-1:0] N_CW     = CW'(NUM_FRAMES);
  localparam logic [KW-1:0] TOP_K    = KW'(TOP_ORDER);

  // Index of the highest set bit, used to size a block from a run length.
  function automatic logic [KW-1:0] msb_index(logic [CW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int b = 0; b < CW; b++) begin
      if (v[b]) begin
        r = KW'(b);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d, ret_q, ret_d;

  logic [LW-1:0] head_q [TOP_ORDER+1];
  logic [LW-1:0] head_d [TOP_ORDER+1];

  logic [CW-1:0]   i_q, i_d, j_q, j_d, endc_q, endc_d;
  logic [FW-1:0]   blk_q, blk_d, bud_q, bud_d, pf_q, pf_d;
  logic [KW-1:0]   k_q, k_d, cur_q, cur_d, req_q, req_d, pk_q, pk_d;
  logic [ST_W-1:0] pst_q, pst_d;
  logic [MODE_W-1:0] mode_q, mode_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [FW-1:0]       res_frame_q, res_frame_d;
  logic [KW-1:0]       res_order_q, res_order_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [FRAME_W-1:0]  out_frame_q;
  logic [ORDER_W-1:0]  out_order_q;
  logic                out_load;

  // Table ports.
  logic [FW-1:0]   rd_addr;
  logic            st_we, ord_we, nxt_we, prv_we;
  logic [FW-1:0]   st_wa, ord_wa, nxt_wa, prv_wa;
  logic [ST_W-1:0] st_wd, st_rd;
  logic [KW-1:0]   ord_wd, ord_rd;
  logic [LW-1:0]   nxt_wd, nxt_rd, prv_wd, prv_rd;

  // Scratch values of the sequencer.
  logic [CW-1:0] jn, run, lowbit, lim, bud_sum, bud_x;
  logic          scan_free, scan_stop;
  logic [KW-1:0] blk_k, ord_k, cur_m1;
  logic [HW-1:0] kh, pkh;
  logic          accept;

  assign accept = req_i.valid && req_i.ready;
  assign kh     = k_q[HW-1:0];
  assign pkh    = pk_q[HW-1:0];

  // Largest block the build scan may form at frame i: its alignment, capped at the top order.
  assign lowbit = i_q & (~i_q + CW'(1));
  assign lim    = (i_q == '0 || lowbit > TOP_SIZE) ? TOP_SIZE : lowbit;
  assign jn        = j_q + CW'(1);
  assign scan_free = (st_rd != ST_RESERVED);
  assign run       = (scan_free ? jn : j_q) - i_q;
  assign scan_stop = !scan_free || ((jn - i_q) == lim) || (jn == N_CW);
  assign blk_k     = msb_index(run);
  assign ord_k     = (ord_rd > TOP_K) ? TOP_K : ord_rd;
  assign cur_m1    = cur_q - KW'(1);
  assign bud_sum   = CW'(blk_q) + (CW'(1) << cur_m1);
  assign bud_x     = CW'(blk_q) ^ (CW'(1) << k_q);

  bpa_ram #(.WIDTH(ST_W)) u_status (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(rd_addr), .rdata_o(st_rd)
  );
  bpa_ram #(.WIDTH(KW)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd), .raddr_i(rd_addr),
    .rdata_o(ord_rd)
  );
  bpa_ram #(.WIDTH(LW)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd), .raddr_i(rd_addr),
    .rdata_o(nxt_rd)
  );
  bpa_ram #(.WIDTH(LW)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd), .raddr_i(rd_addr),
    .rdata_o(prv_rd)
  );

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    head_d  = head_q;
    i_d = i_q; j_d = j_q; endc_d = endc_q;
    blk_d = blk_q; bud_d = bud_q; pf_d = pf_q;
    k_d = k_q; cur_d = cur_q; req_d = req_q; pk_d = pk_q; pst_d = pst_q;
    mode_d = mode_q;
    res_status_d = res_status_q; res_frame_d = res_frame_q; res_order_d = res_order_q;
    out_load = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    rd_addr = '0;
    st_we = 1'b0;  st_wa = '0;  st_wd = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;

    unique case (state_q)
      // Clearing pass after reset: every frame unowned with null links.
      S_CLR: begin
        st_we = 1'b1;  st_wa = i_q[FW-1:0];  st_wd = ST_UNOWNED;
        nxt_we = 1'b1; nxt_wa = i_q[FW-1:0]; nxt_wd = LINK_NULL;
        prv_we = 1'b1; prv_wa = i_q[FW-1:0]; prv_wd = LINK_NULL;
        if (i_q == N_CW - CW'(1)) begin
          i_d = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + CW'(1);
        end
      end

      S_IDLE: begin
        rd_addr = FW'(req_i.first_frame);
        if (accept) begin
          mode_d       = req_i.mode;
          res_status_d = RES_DONE;
          res_frame_d  = '0;
          res_order_d  = '0;
          unique case (req_i.mode)
            MODE_RESERVE: begin
              i_d    = CW'(req_i.first_frame);
              endc_d = (CW'(req_i.end_frame) > N_CW) ? N_CW : CW'(req_i.end_frame);
              state_d = S_RES;
            end
            MODE_BUILD: begin
              for (int h = 0; h <= TOP_ORDER; h++) begin
                head_d[h] = LINK_NULL;
              end
              i_d = '0;
              state_d = S_B1R;
            end
            MODE_ALLOC: begin
              if (CW'(req_i.req_order) > CW'(TOP_ORDER)) begin
                res_status_d = RES_NO_BLOCK;
                state_d = S_OUT;
              end else begin
                req_d = KW'(req_i.req_order);
                k_d   = KW'(req_i.req_order);
                state_d = S_AS;
              end
            end
            default: begin
              blk_d = FW'(req_i.first_frame);
              if (CW'(req_i.first_frame) >= N_CW) begin
                res_status_d = RES_NOT_ALLOC;
                state_d = S_OUT;
              end else begin
                state_d = S_F1;
              end
            end
          endcase
        end
      end

      S_RES: begin
        if (i_q < endc_q) begin
          st_we = 1'b1; st_wa = i_q[FW-1:0]; st_wd = ST_RESERVED;
          i_d = i_q + CW'(1);
        end else begin
          state_d = S_OUT;
        end
      end

      // Build, first pass: forget allocations, keep reserved marks, clear links.
      S_B1R: begin
        rd_addr = i_q[FW-1:0];
        state_d = S_B1W;
      end
      S_B1W: begin
        st_we  = (st_rd != ST_RESERVED); st_wa = i_q[FW-1:0]; st_wd = ST_UNOWNED;
        ord_we = 1'b1; ord_wa = i_q[FW-1:0]; ord_wd = '0;
        nxt_we = 1'b1; nxt_wa = i_q[FW-1:0]; nxt_wd = LINK_NULL;
        prv_we = 1'b1; prv_wa = i_q[FW-1:0]; prv_wd = LINK_NULL;
        if (i_q == N_CW - CW'(1)) begin
          i_d = '0;
          state_d = S_B2;
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_B1R;
        end
      end

      // Build, second pass: measure the free run at frame i up to its alignment limit.
      S_B2: begin
        if (i_q >= N_CW) begin
          state_d = S_OUT;
        end else begin
          j_d = i_q;
          state_d = S_B2R;
        end
      end
      S_B2R: begin
        rd_addr = j_q[FW-1:0];
        state_d = S_B2C;
      end
      S_B2C: begin
        if (!scan_stop) begin
          j_d = jn;
          state_d = S_B2R;
        end else if (run == '0) begin
          i_d = i_q + CW'(1);
          state_d = S_B2;
        end else begin
          pf_d  = i_q[FW-1:0];
          pk_d  = blk_k;
          pst_d = ST_W'(blk_k);
          i_d   = i_q + (CW'(1) << blk_k);
          ret_d = S_B2;
          state_d = S_P1;
        end
      end

      // Allocate: search upward for a non-empty list.
      S_AS: begin
        if (k_q > TOP_K) begin
          res_status_d = RES_NO_BLOCK;
          state_d = S_OUT;
        end else if (head_q[kh] == LINK_NULL) begin
          k_d = k_q + KW'(1);
        end else begin
          blk_d   = head_q[kh][FW-1:0];
          rd_addr = head_q[kh][FW-1:0];
          state_d = S_AN;
        end
      end
      S_AN: begin
        head_d[kh] = nxt_rd;
        if (nxt_rd != LINK_NULL) begin
          prv_we = 1'b1; prv_wa = nxt_rd[FW-1:0]; prv_wd = LINK_NULL;
        end
        cur_d = k_q;
        state_d = S_AL;
      end
      // Split: push each upper half on the list one order below.
      S_AL: begin
        if (cur_q > req_q) begin
          cur_d = cur_m1;
          if (bud_sum < N_CW) begin
            pf_d  = bud_sum[FW-1:0];
            pk_d  = cur_m1;
            pst_d = ST_W'(cur_m1);
            ret_d = S_AL;
            state_d = S_P1;
          end
        end else begin
          st_we  = 1'b1; st_wa  = blk_q; st_wd  = ST_ALLOCATED;
          ord_we = 1'b1; ord_wa = blk_q; ord_wd = req_q;
          nxt_we = 1'b1; nxt_wa = blk_q; nxt_wd = LINK_NULL;
          prv_we = 1'b1; prv_wa = blk_q; prv_wd = LINK_NULL;
          res_frame_d = blk_q;
          res_order_d = req_q;
          state_d = S_OUT;
        end
      end

      // Free: check the frame, then merge with free buddies of equal order.
      S_F1: begin
        if (st_rd != ST_ALLOCATED) begin
          res_status_d = RES_NOT_ALLOC;
          state_d = S_OUT;
        end else begin
          k_d = ord_k;
          st_we = 1'b1; st_wa = blk_q; st_wd = ST_W'(ord_k);
          state_d = S_FM;
        end
      end
      S_FM: begin
        if (k_q >= TOP_K || bud_x >= N_CW) begin
          state_d = S_FE;
        end else begin
          bud_d   = bud_x[FW-1:0];
          rd_addr = bud_x[FW-1:0];
          state_d = S_FB;
        end
      end
      S_FB: begin
        if (st_rd != ST_W'(k_q)) begin
          state_d = S_FE;
        end else begin
          if (head_q[kh] == LW'(bud_q)) begin
            head_d[kh] = nxt_rd;
            if (nxt_rd != LINK_NULL) begin
              prv_we = 1'b1; prv_wa = nxt_rd[FW-1:0]; prv_wd = LINK_NULL;
            end
          end else if (prv_rd != LINK_NULL) begin
            nxt_we = 1'b1; nxt_wa = prv_rd[FW-1:0]; nxt_wd = nxt_rd;
            if (nxt_rd != LINK_NULL) begin
              prv_we = 1'b1; prv_wa = nxt_rd[FW-1:0]; prv_wd = prv_rd;
            end
          end
          state_d = S_FC;
        end
      end
      // The upper frame of the merged pair stops being a block head.
      S_FC: begin
        st_we  = 1'b1; ord_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
        st_wd  = ST_UNOWNED; ord_wd = '0; nxt_wd = LINK_NULL; prv_wd = LINK_NULL;
        if (bud_q < blk_q) begin
          st_wa = blk_q; ord_wa = blk_q; nxt_wa = blk_q; prv_wa = blk_q;
          blk_d = bud_q;
        end else begin
          st_wa = bud_q; ord_wa = bud_q; nxt_wa = bud_q; prv_wa = bud_q;
        end
        k_d = k_q + KW'(1);
        state_d = S_FM;
      end
      S_FE: begin
        ord_we = 1'b1; ord_wa = blk_q; ord_wd = '0;
        pf_d  = blk_q;
        pk_d  = k_q;
        pst_d = ST_W'(k_q);
        res_frame_d = blk_q;
        res_order_d = k_q;
        ret_d = S_OUT;
        state_d = S_P1;
      end

      // Push frame pf on list pk in S_P1 and then S_P2, since both steps write the prev table.
      S_P1: begin
        st_we  = 1'b1; st_wa  = pf_q; st_wd  = pst_q;
        nxt_we = 1'b1; nxt_wa = pf_q; nxt_wd = head_q[pkh];
        prv_we = 1'b1; prv_wa = pf_q; prv_wd = LINK_NULL;
        state_d = S_P2;
      end
      S_P2: begin
        if (head_q[pkh] != LINK_NULL) begin
          prv_we = 1'b1; prv_wa = head_q[pkh][FW-1:0]; prv_wd = LW'(pf_q);
        end
        head_d[pkh] = LW'(pf_q);
        state_d = ret_q;
      end

      S_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= S_IDLE;
      i_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int h = 0; h <= TOP_ORDER; h++) begin
        head_q[h] <= LINK_NULL;
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      i_q     <= i_d;
      rsp_valid_q <= rsp_valid_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; endc_q <= endc_d;
    blk_q <= blk_d; bud_q <= bud_d; pf_q <= pf_d;
    k_q <= k_d; cur_q <= cur_d; req_q <= req_d; pk_q <= pk_d; pst_q <= pst_d;
    mode_q <= mode_d;
    res_status_q <= res_status_d; res_frame_q <= res_frame_d; res_order_q <= res_order_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_frame_q  <= FRAME_W'(res_frame_q);
      out_order_q  <= ORDER_W'(res_order_q);
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.block_frame = out_frame_q;
  assign rsp_o.block_order = out_order_q;

  // Once a request is accepted, ready drops while the block works on it.
  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, !req_i.ready)
  // Handing over a finished response always leaves it visible on the next cycle.
  `ASSERT_NXT(a_out_shows, clk_i, rst_ni, out_load, rsp_o.valid)
  // The not-allocated status only comes from a free request.
  `ASSERT_IMP(a_bad_free_only, clk_i, rst_ni,
              (state_q == S_OUT) && (res_status_q == RES_NOT_ALLOC), mode_q == MODE_FREE)

endmodule

/* sim/tb_buddy_page_allocator.sv */
// Self-checking testbench of the buddy page allocator with a built-in allocator predictor.
`timescale 1ns / 1ps

module tb_buddy_page_allocator;
  import bpa_pkg::*;

  typedef struct {
    result_e            status;
    logic [FRAME_W-1:0] block_frame;
    logic [ORDER_W-1:0] block_order;
  } alloc_result_t;

  // The scoreboard holds its own copy of the frame tables and free lists. Each accepted
  // request is replayed on that copy, and the outcome waits in a queue for the response.
  class alloc_scoreboard;
    logic [ST_W-1:0]    frame_state [NUM_FRAMES];
    logic [ORDER_W-1:0] frame_order [NUM_FRAMES];
    int unsigned        next_frame  [NUM_FRAMES];
    int unsigned        prev_frame  [NUM_FRAMES];
    int unsigned        list_head   [TOP_ORDER+1];
    int unsigned        held_below  [NUM_FRAMES+1];
    alloc_result_t      pending_results[$];
    int                 error_count;

    function new();
      error_count = 0;
      for (int f = 0; f < NUM_FRAMES; f++) begin
        clear_frame(f);
      end
      for (int k = 0; k <= TOP_ORDER; k++) begin
        list_head[k] = NUM_FRAMES;
      end
    endfunction

    function void clear_frame(int unsigned f);
      frame_state[f] = ST_UNOWNED;
      frame_order[f] = '0;
      next_frame[f]  = NUM_FRAMES;
      prev_frame[f]  = NUM_FRAMES;
    endfunction

    function void push_block(int unsigned k, int unsigned f);
      int unsigned h;
      h = list_head[k];
      next_frame[f] = h;
      prev_frame[f] = NUM_FRAMES;
      if (h < NUM_FRAMES) prev_frame[h] = f;
      list_head[k] = f;
    endfunction

    function void unlink_block(int unsigned k, int unsigned f);
      int unsigned nx;
      int unsigned pv;
      nx = next_frame[f];
      pv = prev_frame[f];
      if (list_head[k] == f) begin
        list_head[k] = nx;
        if (nx < NUM_FRAMES) prev_frame[nx] = NUM_FRAMES;
      end else if (pv < NUM_FRAMES) begin
        next_frame[pv] = nx;
        if (nx < NUM_FRAMES) prev_frame[nx] = pv;
      end
    endfunction

    function void rebuild_lists();
      int unsigned i;
      int unsigned k;
      bit          held;
      for (k = 0; k <= TOP_ORDER; k++) list_head[k] = NUM_FRAMES;
      held_below[0] = 0;
      for (i = 0; i < NUM_FRAMES; i++) begin
        held = (frame_state[i] == ST_RESERVED);
        frame_order[i] = '0;
        next_frame[i] = NUM_FRAMES;
        prev_frame[i] = NUM_FRAMES;
        if (!held) frame_state[i] = ST_UNOWNED;
        held_below[i+1] = held_below[i] + held;
      end
      i = 0;
      while (i < NUM_FRAMES) begin
        if (frame_state[i] == ST_RESERVED) begin
          i++;
        end else begin
          k = TOP_ORDER;
          while (k > 0) begin
            if ((i & ((1 << k) - 1)) == 0 && i + (1 << k) <= NUM_FRAMES &&
                held_below[i + (1 << k)] == held_below[i]) break;
            k--;
          end
          frame_state[i] = ST_W'(k);
          push_block(k, i);
          i += (1 << k);
        end
      end
    endfunction

    // Replays one accepted request and returns the block frame of a good allocation,
    // or NUM_FRAMES when nothing was allocated.
    function int unsigned note_request(mode_e mode, logic [FRAME_W-1:0] first,
                                       logic [END_W-1:0] last, logic [ORDER_W-1:0] ord);
      alloc_result_t r;
      int unsigned   stop;
      int unsigned   blk;
      int unsigned   bud;
      int unsigned   k;
      int unsigned   cur;
      int unsigned   got;
      r.status = RES_DONE;
      r.block_frame = '0;
      r.block_order = '0;
      got = NUM_FRAMES;
      case (mode)
        MODE_RESERVE: begin
          stop = (last > NUM_FRAMES) ? NUM_FRAMES : last;
          for (int unsigned f = first; f < stop; f++) frame_state[f] = ST_RESERVED;
        end
        MODE_BUILD: begin
          rebuild_lists();
        end
        MODE_ALLOC: begin
          r.status = RES_NO_BLOCK;
          for (k = ord; k <= TOP_ORDER; k++) begin
            blk = list_head[k];
            if (blk < NUM_FRAMES) begin
              list_head[k] = next_frame[blk];
              if (next_frame[blk] < NUM_FRAMES) prev_frame[next_frame[blk]] = NUM_FRAMES;
              // Split off upper halves down to the requested order.
              cur = k;
              while (cur > ord) begin
                cur--;
                bud = blk + (1 << cur);
                if (bud < NUM_FRAMES) begin
                  frame_state[bud] = ST_W'(cur);
                  push_block(cur, bud);
                end
              end
              frame_state[blk] = ST_ALLOCATED;
              next_frame[blk] = NUM_FRAMES;
              prev_frame[blk] = NUM_FRAMES;
              frame_order[blk] = ord;
              r.status = RES_DONE;
              r.block_frame = FRAME_W'(blk);
              r.block_order = ord;
              got = blk;
              break;
            end
          end
        end
        default: begin
          blk = first;
          if (frame_state[blk] != ST_ALLOCATED) begin
            r.status = RES_NOT_ALLOC;
          end else begin
            k = frame_order[blk];
            if (k > TOP_ORDER) k = TOP_ORDER;
            frame_state[blk] = ST_W'(k);
            // Merge with the buddy while it heads a free block of the same order.
            while (k < TOP_ORDER) begin
              bud = blk ^ (1 << k);
              if (bud >= NUM_FRAMES || frame_state[bud] != ST_W'(k)) break;
              unlink_block(k, bud);
              if (bud < blk) begin
                clear_frame(blk);
                blk = bud;
              end else begin
                clear_frame(bud);
              end
              k++;
            end
            frame_state[blk] = ST_W'(k);
            frame_order[blk] = '0;
            push_block(k, blk);
            r.block_frame = FRAME_W'(blk);
            r.block_order = ORDER_W'(k);
          end
        end
      endcase
      pending_results.push_back(r);
      return got;
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [FRAME_W-1:0] frame,
                                 logic [ORDER_W-1:0] ord);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, status);
        error_count++;
      end
      if (frame !== e.block_frame) begin
        $error("block_frame mismatch: expected %0d, actual %0d", e.block_frame, frame);
        error_count++;
      end
      if (ord !== e.block_order) begin
        $error("block_order mismatch: expected %0d, actual %0d", e.block_order, ord);
        error_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  buddy_page_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  alloc_scoreboard  sb = new();
  int unsigned      live_blocks[$];
  bit               gaps_on;
  int               hold_off_cycles;
  int               rsp_gap;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Response side: checks every accepted response and stalls in random bursts, or for a
  // long stretch when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        sb.check_response(rsp_bus.status, rsp_bus.block_frame, rsp_bus.block_order);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        rsp_gap <= $urandom_range(0, 3);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Offers one request, with an occasional idle burst ahead of it, and waits until the
  // block takes it. The valid stays high afterwards so back-to-back requests need no
  // second assignment in the same step.
  task automatic send_request(mode_e mode, int unsigned first, int unsigned last,
                              int unsigned ord);
    int unsigned got;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= mode;
    req_bus.first_frame <= FRAME_W'(first);
    req_bus.end_frame   <= END_W'(last);
    req_bus.req_order   <= ORDER_W'(ord);
    do @(posedge clk_i); while (!req_bus.ready);
    got = sb.note_request(mode, FRAME_W'(first), END_W'(last), ORDER_W'(ord));
    if (got < NUM_FRAMES) live_blocks.push_back(got);
    if (mode == MODE_BUILD) live_blocks.delete();
  endtask

  task automatic free_live_block();
    int idx;
    if (live_blocks.size() == 0) begin
      send_request(MODE_FREE, $urandom_range(0, NUM_FRAMES - 1), 0, 0);
    end else begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      send_request(MODE_FREE, live_blocks[idx], $urandom_range(0, 2047), $urandom_range(0, 15));
      live_blocks.delete(idx);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly small orders, now and then a large one, rarely one beyond the top order.
  function automatic int unsigned pick_order();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(0, 3);
    if (p < 95) return $urandom_range(4, TOP_ORDER);
    return $urandom_range(TOP_ORDER + 1, 15);
  endfunction

  task automatic reserve_small_range();
    int unsigned first;
    first = $urandom_range(0, NUM_FRAMES - 1);
    send_request(MODE_RESERVE, first, first + $urandom_range(0, 6), $urandom_range(0, 15));
  endtask

  initial begin
    int unsigned pick;
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.mode          = MODE_RESERVE;
    req_bus.first_frame   = '0;
    req_bus.end_frame     = '0;
    req_bus.req_order     = '0;
    rsp_bus.ready         = 1'b0;
    gaps_on               = 1'b1;
    hold_off_cycles       = 0;
    rsp_gap               = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty lists, bad frees, reserve clipping and an inverted range,
    // then a build and allocations of small, large and out-of-range orders.
    send_request(MODE_ALLOC, 0, 0, 0);
    send_request(MODE_FREE, 1023, 0, 0);
    send_request(MODE_RESERVE, 10, 5, 0);
    send_request(MODE_RESERVE, 0, 0, 0);
    send_request(MODE_RESERVE, 1020, 2047, 15);
    send_request(MODE_RESERVE, 37, 40, 0);
    send_request(MODE_BUILD, 0, 0, 0);
    send_request(MODE_ALLOC, 0, 0, 0);
    send_request(MODE_ALLOC, 0, 0, TOP_ORDER);
    send_request(MODE_ALLOC, 0, 0, 9);
    send_request(MODE_ALLOC, 0, 0, 15);
    send_request(MODE_ALLOC, 0, 0, 3);
    send_request(MODE_ALLOC, 0, 0, 1);
    send_request(MODE_FREE, 1023, 0, 0);
    send_request(MODE_FREE, live_blocks[0], 0, 0);
    send_request(MODE_FREE, live_blocks[0], 0, 0);
    live_blocks.delete(0);
    while (live_blocks.size() != 0) free_live_block();
    send_request(MODE_ALLOC, 0, 0, 8);
    send_request(MODE_ALLOC, 0, 0, 8);
    send_request(MODE_ALLOC, 0, 0, 8);
    send_request(MODE_RESERVE, 512, 514, 0);
    free_live_block();

    // Random part: rounds of a few reservations and a rebuild, then a mix of allocations
    // and frees that mostly return blocks the allocator handed out.
    for (int round = 0; round < 9; round++) begin
      if (round == 8) gaps_on = 1'b0;
      repeat ($urandom_range(0, 2)) reserve_small_range();
      send_request(MODE_BUILD, 0, 0, 0);
      for (int n = 0; n < 95; n++) begin
        if (round == 3 && n == 40) hold_off_cycles = 400;
        if (round == 5 && n == 50) begin
          // The request is withdrawn so the idle block does not take it a second time.
          req_bus.valid <= 1'b0;
          wait_drained();
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_request(MODE_ALLOC, $urandom_range(0, NUM_FRAMES - 1),
                       $urandom_range(0, 2047), pick_order());
        end else if (pick < 92) begin
          free_live_block();
        end else if (pick < 97) begin
          send_request(MODE_FREE, $urandom_range(0, NUM_FRAMES - 1), 0, 0);
        end else begin
          reserve_small_range();
        end
      end
    end

    req_bus.valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("buddy_page_allocator verification clean");
    end else begin
      $display("buddy_page_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("buddy_page_allocator verification failed");
    $finish;
  end

endmodule
